@@ src/svga_pkg.sv @@
// Package for the state vector gate engine: command and status codes,
// state machine type and shared constants. No dependencies.
`default_nettype none
package svga_pkg;
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_WR_AMP = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RD_AMP = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_MAT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GATE1  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GATE2  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_REPEAT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CLR, S_GRD, S_GWAIT, S_GLAST, S_GMAC, S_GWR, S_GNEXT, S_DONE,
        S_INIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request
        logic amp_wr;    // single amplitude write
        logic rd;        // single amplitude read
        logic clr_wr;    // clear sweep write
        logic grd;       // gate group read issue
        logic gcap;      // capture read data into group buffer
        logic mac;       // one multiply-accumulate step
        logic gwr;       // write one group result
        logic mat_wr;
    } t_cmd;
endpackage
`default_nettype wire

@@ src/svga_if.sv @@
// Valid/ready channel interface with payload struct-free fields.
// Depends on nothing.
`default_nettype none
interface svga_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [9:0]  amp_index;
    logic [1:0]  mat_row;
    logic [1:0]  mat_col;
    logic signed [15:0] value_re;
    logic signed [15:0] value_im;
    logic [3:0]  qubit_a;
    logic [3:0]  qubit_b;
    modport source (output valid, command, amp_index, mat_row, mat_col, value_re,
                    value_im, qubit_a, qubit_b, input ready);
    modport sink (input valid, command, amp_index, mat_row, mat_col, value_re,
                  value_im, qubit_a, qubit_b, output ready);
endinterface

interface svga_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] read_re;
    logic signed [15:0] read_im;
    logic [1:0]  status;
    modport source (output valid, read_re, read_im, status, input ready);
    modport sink (input valid, read_re, read_im, status, output ready);
endinterface
`default_nettype wire

@@ src/svga_ctrl.sv @@
// Controller: sequences single accesses, clear sweep and gate walks.
// Depends on svga_pkg.
`default_nettype none
module svga_ctrl import svga_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic [2:0] i_command,
    input  wire logic i_bad,        // range or repeat error on incoming request
    input  wire logic i_base_last,  // last group base
    input  wire logic i_k_last,     // last group member
    input  wire logic i_c_last,     // last column
    input  wire logic i_out_free,
    input  wire logic i_clr_last,
    output logic      o_in_ready,
    output logic      o_done,
    output t_cmd      o_cmd,
    output logic [1:0] o_step       // 0 hold,1 next k,2 next c,3 next base
);
    t_state r_state, n_state;

    // reset starts with a clear sweep of the amplitude store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_INIT;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_done     = 1'b0;
        o_step     = 2'd0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_out_free;
                if (i_in_valid && i_out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_bad) n_state = S_DONE;
                    else begin
                        unique case (i_command)
                            CMD_WR_AMP: begin o_cmd.amp_wr = 1'b1; n_state = S_DONE; end
                            CMD_WR_MAT: begin o_cmd.mat_wr = 1'b1; n_state = S_DONE; end
                            CMD_RD_AMP: n_state = S_RD;
                            CMD_CLEAR:  n_state = S_CLR;
                            CMD_GATE1, CMD_GATE2: n_state = S_GRD;
                            default:    n_state = S_DONE;
                        endcase
                    end
                end
            end
            S_INIT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_clr_last) n_state = S_IDLE;
            end
            S_RD: begin o_cmd.rd = 1'b1; n_state = S_DONE; end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_clr_last) n_state = S_DONE;
            end
            S_GRD: begin
                o_cmd.grd = 1'b1; o_step = 2'd1;
                n_state = i_k_last ? S_GLAST : S_GWAIT;
            end
            S_GWAIT: begin
                o_cmd.grd = 1'b1; o_cmd.gcap = 1'b1; o_step = 2'd1;
                if (i_k_last) n_state = S_GLAST;
            end
            S_GLAST: begin o_cmd.gcap = 1'b1; n_state = S_GMAC; end
            S_GMAC: begin
                o_cmd.mac = 1'b1; o_step = 2'd2;
                if (i_c_last) n_state = S_GWR;
            end
            S_GWR: begin
                o_cmd.gwr = 1'b1; o_step = 2'd1;
                if (i_k_last) n_state = S_GNEXT;
                else n_state = S_GMAC;
            end
            S_GNEXT: begin
                o_step = 2'd3;
                n_state = i_base_last ? S_DONE : S_GRD;
            end
            S_DONE: begin o_done = 1'b1; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ src/svga_dp.sv @@
// Datapath: amplitude memory, gate matrix, complex MAC and result register.
// Depends on svga_pkg.
`default_nettype none
module svga_dp import svga_pkg::*; #(
    parameter int MAX_QUBITS = 10,
    parameter int AMP_WIDTH  = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic [1:0] i_step,
    input  wire logic i_done,
    input  wire logic [3:0] i_qubit_count,
    input  wire logic [2:0] i_command,
    input  wire logic [9:0] i_amp_index,
    input  wire logic [1:0] i_mat_row,
    input  wire logic [1:0] i_mat_col,
    input  wire logic signed [15:0] i_value_re,
    input  wire logic signed [15:0] i_value_im,
    input  wire logic [3:0] i_qubit_a,
    input  wire logic [3:0] i_qubit_b,
    output logic      o_bad,
    output logic      o_base_last,
    output logic      o_k_last,
    output logic      o_c_last,
    output logic      o_clr_last,
    input  wire logic i_out_ready,
    output logic      o_out_valid,
    output logic signed [15:0] o_read_re,
    output logic signed [15:0] o_read_im,
    output logic [1:0] o_status
);
    localparam int DEPTH = 1 << MAX_QUBITS;
    localparam int AW = MAX_QUBITS;
    localparam int FRAC = AMP_WIDTH - 2;
    localparam int PW = 2 * AMP_WIDTH;
    localparam int SW = PW - FRAC + 3;

    logic [2*AMP_WIDTH-1:0] mem [DEPTH];
    logic signed [15:0] r_mat_re [16];
    logic signed [15:0] r_mat_im [16];
    logic [15:0] r_mat_vld;

    // effective qubit count
    logic [4:0] eff_n;
    always_comb begin
        if (i_qubit_count == 4'd0) eff_n = 5'd1;
        else if (32'(i_qubit_count) > MAX_QUBITS) eff_n = 5'(MAX_QUBITS);
        else eff_n = {1'b0, i_qubit_count};
    end

    function automatic logic signed [AMP_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi, lo;
        hi = SW'((64'sd1 <<< (AMP_WIDTH - 1)) - 1);
        lo = -hi - SW'(1);
        if (v > hi) return hi[AMP_WIDTH-1:0];
        else if (v < lo) return lo[AMP_WIDTH-1:0];
        else return v[AMP_WIDTH-1:0];
    endfunction

    // request-time checks
    logic idx_bad, qa_bad, qb_bad, bad_c;
    logic [1:0] st_c;
    always_comb begin
        idx_bad = (20'(i_amp_index) >> eff_n) != 20'd0;
        qa_bad  = {1'b0, i_qubit_a} >= eff_n;
        qb_bad  = {1'b0, i_qubit_b} >= eff_n;
        st_c = ST_OK;
        unique case (i_command)
            CMD_WR_AMP, CMD_RD_AMP: if (idx_bad) st_c = ST_RANGE;
            CMD_WR_MAT, CMD_CLEAR: st_c = ST_OK;
            CMD_GATE1: if (qa_bad) st_c = ST_RANGE;
            CMD_GATE2: begin
                if (qa_bad || qb_bad) st_c = ST_RANGE;
                else if (i_qubit_a == i_qubit_b) st_c = ST_REPEAT;
            end
            default: st_c = ST_RANGE;
        endcase
        bad_c = st_c != ST_OK;
    end
    assign o_bad = bad_c;

    // captured request
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_ma, r_mb, r_span;
    logic r_two;
    logic [1:0] r_status;
    logic [2:0] r_cmd;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx    <= AW'(i_amp_index);
            r_ma     <= AW'(1) << i_qubit_a;
            r_mb     <= AW'(1) << i_qubit_b;
            r_span   <= AW'((21'd1 << eff_n) - 21'd1);
            r_two    <= i_command == CMD_GATE2;
            r_status <= st_c;
            r_cmd    <= i_command;
        end
    end

    // gate walk counters
    logic [AW:0] r_base;
    logic [1:0] r_k, r_c, r_rk;
    logic [AW-1:0] gmask;
    logic [AW-1:0] base_a, k_mask, addr_k;
    assign gmask = r_two ? (r_ma | r_mb) : r_ma;
    assign base_a = r_base[AW-1:0];
    assign k_mask = (r_k[0] ? r_ma : '0) | (r_k[1] ? r_mb : '0);
    assign addr_k = base_a | k_mask;
    assign o_k_last = r_two ? (r_k == 2'd3) : (r_k == 2'd1);
    assign o_c_last = r_two ? (r_c == 2'd3) : (r_c == 2'd1);

    // next valid base: skip bases touching target bits; base only grows
    logic [AW:0] nb;
    always_comb begin
        nb = (r_base | {1'b0, gmask}) + (AW+1)'(1);
        nb = nb & ~{1'b0, gmask};
    end
    assign o_base_last = ({1'b0, base_a} | {1'b0, gmask}) >= {1'b0, r_span};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= '0; r_k <= '0; r_c <= '0; r_rk <= '0;
        end else begin
            unique case (i_step)
                2'd1: begin
                    r_k <= o_k_last ? 2'd0 : r_k + 2'd1;
                    r_c <= '0;
                end
                2'd2: r_c <= r_c + 2'd1;
                2'd3: begin r_base <= nb; r_k <= '0; end
                default: ;
            endcase
            if (i_cmd.gcap) r_rk <= r_rk + 2'd1;
            if (i_step == 2'd3) r_rk <= '0;
        end
    end

    // clear sweep counter, also used by the sweep after reset
    logic [AW-1:0] r_clr;
    assign o_clr_last = r_clr == AW'(DEPTH - 1);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) r_clr <= '0;
        else if (i_cmd.clr_wr) r_clr <= r_clr + AW'(1);
    end

    // memory port
    logic mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [2*AMP_WIDTH-1:0] mem_wd, r_rdata;
    logic [AW-1:0] one_clr;
    assign one_clr = '0;
    logic signed [AMP_WIDTH-1:0] acc_re_s, acc_im_s;

    always_comb begin
        mem_we = i_cmd.amp_wr | i_cmd.clr_wr | i_cmd.gwr;
        mem_wa = AW'(i_amp_index);
        mem_wd = {AMP_WIDTH'(i_value_re), AMP_WIDTH'(i_value_im)};
        if (i_cmd.amp_wr) begin
            mem_wa = AW'(i_amp_index);
            mem_wd = {sat(SW'(i_value_re)), sat(SW'(i_value_im))};
        end else if (i_cmd.clr_wr) begin
            mem_wa = r_clr;
            mem_wd = (r_clr == one_clr) ?
                {AMP_WIDTH'(64'd1 << FRAC), AMP_WIDTH'(0)} : '0;
        end else if (i_cmd.gwr) begin
            mem_wa = addr_k;
            mem_wd = {acc_re_s, acc_im_s};
        end
        mem_ra = i_cmd.rd ? r_idx : addr_k;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[mem_ra];
    end

    // group buffer
    logic signed [AMP_WIDTH-1:0] r_in_re [4];
    logic signed [AMP_WIDTH-1:0] r_in_im [4];
    always_ff @(posedge i_clk) begin
        if (i_cmd.gcap) begin
            r_in_re[r_rk] <= r_rdata[2*AMP_WIDTH-1:AMP_WIDTH];
            r_in_im[r_rk] <= r_rdata[AMP_WIDTH-1:0];
        end
    end

    // matrix store, reset clears valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mat_vld <= '0;
        else if (i_cmd.mat_wr) r_mat_vld[{i_mat_row, i_mat_col}] <= 1'b1;
        if (i_cmd.mat_wr) begin
            r_mat_re[{i_mat_row, i_mat_col}] <= i_value_re;
            r_mat_im[{i_mat_row, i_mat_col}] <= i_value_im;
        end
    end

    // complex MAC: four products, floor-shifted, summed exactly
    logic [3:0] mi;
    logic signed [15:0] m_re, m_im;
    logic signed [AMP_WIDTH-1:0] a_re, a_im;
    logic signed [AMP_WIDTH+15:0] p_rr, p_ii, p_ri, p_ir;
    logic signed [SW-1:0] r_acc_re, r_acc_im;
    assign mi = {r_k, r_c};
    assign m_re = r_mat_vld[mi] ? r_mat_re[mi] : 16'sd0;
    assign m_im = r_mat_vld[mi] ? r_mat_im[mi] : 16'sd0;
    assign a_re = r_in_re[r_c];
    assign a_im = r_in_im[r_c];
    assign p_rr = m_re * a_re;
    assign p_ii = m_im * a_im;
    assign p_ri = m_re * a_im;
    assign p_ir = m_im * a_re;
    always_ff @(posedge i_clk) begin
        if (i_cmd.gwr || i_cmd.load) begin
            r_acc_re <= '0; r_acc_im <= '0;
        end else if (i_cmd.mac) begin
            r_acc_re <= r_acc_re + SW'(p_rr >>> FRAC) - SW'(p_ii >>> FRAC);
            r_acc_im <= r_acc_im + SW'(p_ri >>> FRAC) + SW'(p_ir >>> FRAC);
        end
    end
    assign acc_re_s = sat(r_acc_re);
    assign acc_im_s = sat(r_acc_im);

    // result register
    logic rd_pend;
    logic r_rdv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rdv <= 1'b0;
        else r_rdv <= i_cmd.rd;
    end
    assign rd_pend = r_rdv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_out_valid <= 1'b0;
        else if (i_done) o_out_valid <= 1'b1;
        else if (i_out_ready) o_out_valid <= 1'b0;
        if (i_done) begin
            o_status <= r_status;
            if (rd_pend && r_cmd == CMD_RD_AMP && r_status == ST_OK) begin
                o_read_re <= 16'(r_rdata[2*AMP_WIDTH-1:AMP_WIDTH]);
                o_read_im <= 16'(r_rdata[AMP_WIDTH-1:0]);
            end else begin
                o_read_re <= '0;
                o_read_im <= '0;
            end
        end
    end
endmodule
`default_nettype wire

@@ src/state_vector_gate_apply.sv @@
// Top level of the state vector gate engine: controller and datapath.
// Depends on svga_pkg, svga_if, svga_ctrl, svga_dp.
//
//  channel   dir  handshake     payload
//  in        in   valid/ready   command, amp_index, mat_row/col, value, qubits
//  out       out  valid/ready   read_re, read_im, status
//  cfg       in   i_cfg_we      i_cfg_data (qubit_count)
//
// A gate walks the state vector group by group, g the group size, through the
// single memory port and one complex MAC.
// Reset restores qubit_count and the matrix and sweeps the amplitude store
// back to the ground state; no request is taken until the sweep is done.
// One request at a time; a new one waits until the result has been taken.
`default_nettype none
module state_vector_gate_apply import svga_pkg::*; #(
    parameter int MAX_QUBITS = 10,
    parameter int AMP_WIDTH  = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic [3:0] i_cfg_data,
    svga_in_if.sink   i_in,
    svga_out_if.source o_out
);
    logic [3:0] r_qcount;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_qcount <= 4'd10;
        else if (i_cfg_we) r_qcount <= i_cfg_data;
    end

    t_cmd cmd;
    logic [1:0] step;
    logic bad, base_last, k_last, c_last, clr_last, done, out_free, in_ready;
    logic busy;

    assign out_free = !o_out.valid && !busy;
    assign i_in.ready = in_ready;

    logic r_busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_busy <= 1'b0;
        else if (cmd.load) r_busy <= 1'b1;
        else if (done) r_busy <= 1'b0;
    end
    assign busy = r_busy;

    svga_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(i_in.valid), .i_command(i_in.command), .i_bad(bad),
        .i_base_last(base_last), .i_k_last(k_last), .i_c_last(c_last),
        .i_out_free(out_free), .i_clr_last(clr_last),
        .o_in_ready(in_ready), .o_done(done), .o_cmd(cmd), .o_step(step)
    );

    svga_dp #(.MAX_QUBITS(MAX_QUBITS), .AMP_WIDTH(AMP_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_step(step), .i_done(done),
        .i_qubit_count(r_qcount), .i_command(i_in.command),
        .i_amp_index(i_in.amp_index), .i_mat_row(i_in.mat_row),
        .i_mat_col(i_in.mat_col), .i_value_re(i_in.value_re),
        .i_value_im(i_in.value_im), .i_qubit_a(i_in.qubit_a),
        .i_qubit_b(i_in.qubit_b), .o_bad(bad), .o_base_last(base_last),
        .o_k_last(k_last), .o_c_last(c_last), .o_clr_last(clr_last),
        .i_out_ready(o_out.ready), .o_out_valid(o_out.valid),
        .o_read_re(o_out.read_re), .o_read_im(o_out.read_im),
        .o_status(o_out.status)
    );

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !(i_in.valid && i_in.ready)) else $error("accept while busy");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> o_out.valid) else $error("result lost");
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> r_busy) else $error("busy not set");
endmodule
`default_nettype wire
